### sv/svftm_pkg.sv
// Package for the state-variable filter core: shared types, codes and constants.
// Used by svftm_mul_unit and state_variable_filter_truncated_mult_core; no dependencies.
package svftm_pkg;

    // Datapath widths
    localparam int CALC_W     = 64;   // all sums and products wrap at this width
    localparam int SAMPLE_W   = 19;
    localparam int LOW_OUT_W  = 32;
    localparam int BAND_OUT_W = 48;
    localparam int COEF_W     = 17;   // widest coefficient: k times table entry
    localparam int COL_W      = 6;    // rounding column, 0..63
    localparam int QM_W       = 8;
    localparam int K_W        = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRACTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_ORDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SETUP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_SETUP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SETUP    = 3'd6;

    // Multiplier model codes (code 3 behaves as coefficient recoding)
    localparam logic [1:0] MODEL_EXACT      = 2'd0;
    localparam logic [1:0] MODEL_BOOTH_DATA = 2'd1;
    localparam logic [1:0] MODEL_BOOTH_COEF = 2'd2;

    // Rounding codes of the exact model; Booth model uses floor or half up
    localparam logic [1:0] RND_FLOOR     = 2'd0;
    localparam logic [1:0] RND_TRUNC     = 2'd1;
    localparam logic [1:0] RND_HALF_AWAY = 2'd2;
    localparam logic [1:0] RND_HALF_UP   = 2'd3;

    // Coefficient and column constants
    localparam logic [K_W-1:0]   K_OFFSET        = 9'd256;
    localparam logic [COL_W-1:0] COL_INPUT_BASE  = 6'd9;
    localparam logic [COL_W-1:0] COL_DAMP_SINGLE = 6'd31;
    localparam logic [COL_W-1:0] COL_DAMP_FIRST  = 6'd24;
    localparam logic [COL_W-1:0] COL_DAMP_CHAIN  = 6'd7;
    localparam logic [COL_W-1:0] COL_LOW_BASE    = 6'd39;

    // Damping multiplier table, indexed by resonance
    localparam logic [QM_W-1:0] DAMP_TABLE [32] = '{
        8'd192, 8'd176, 8'd160, 8'd144, 8'd128, 8'd120, 8'd112, 8'd104,
        8'd96,  8'd88,  8'd80,  8'd72,  8'd64,  8'd60,  8'd56,  8'd52,
        8'd48,  8'd44,  8'd40,  8'd36,  8'd32,  8'd30,  8'd28,  8'd26,
        8'd24,  8'd22,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd13
    };

    // Setup register layout: guard columns, rounding, model
    typedef struct packed {
        logic [3:0] guard;
        logic [1:0] rnd;
        logic [1:0] model;
    } mult_setup_t;

    // Product request from the sequencer
    typedef struct packed {
        logic                start;
        mult_setup_t         setup;
        logic [COEF_W-1:0]   coef;
        logic [CALC_W-1:0]   data;
        logic [COL_W-1:0]    col;
    } mul_req_t;

    // Product response to the sequencer
    typedef struct packed {
        logic                done;
        logic [CALC_W-1:0]   result;
    } mul_rsp_t;

endpackage

### sv/state_variable_filter_truncated_mult_core.sv
// Top level of the state-variable filter core: configuration registers,
// product sequencer, integrators and output register. Depends on svftm_pkg, svftm_mul_unit.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  input    | in_valid / in_ready    | sample_eighths (19, signed)
//  output   | out_valid / out_ready  | low_out (32), band_out (48)
//  config   | cfg_wr_en              | cfg_index (3), cfg_data (12)
//
// One transaction runs its three or four products in turn on the shared product
// unit, which scans 1 to BOOTH_DIGITS Booth digits for each product.
// Reset clears the configuration, both integrators and all control state.
// A new transaction is taken while a finished result waits at the output;
// the result is held in the sequencer until the output register frees up.
module state_variable_filter_truncated_mult_core #(
    parameter int STATE_WIDTH  = 48,
    parameter int BOOTH_DIGITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [svftm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [svftm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [svftm_pkg::SAMPLE_W-1:0]  sample_eighths,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [svftm_pkg::LOW_OUT_W-1:0] low_out,
    output logic signed [svftm_pkg::BAND_OUT_W-1:0] band_out
);

    localparam int CW = svftm_pkg::CALC_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INPUT = 6'b000010,
        S_DAMP  = 6'b000100,
        S_CHAIN = 6'b001000,
        S_LOW   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   wait_reg;
    logic   out_valid_reg;

    // configuration
    logic [11:0]                   cutoff_reg;
    logic [4:0]                    resonance_reg;
    logic [3:0]                    frac_reg;
    logic                          order_reg;
    svftm_pkg::mult_setup_t        in_setup_reg;
    svftm_pkg::mult_setup_t        damp_setup_reg;
    svftm_pkg::mult_setup_t        low_setup_reg;

    // datapath
    logic signed [STATE_WIDTH-1:0]        band_reg;
    logic signed [STATE_WIDTH-1:0]        low_reg;
    logic signed [svftm_pkg::SAMPLE_W-1:0] x_reg;
    logic [CW-1:0]                        part_reg;
    logic [CW-1:0]                        tmp_reg;
    logic [svftm_pkg::LOW_OUT_W-1:0]      low_out_reg;
    logic [svftm_pkg::BAND_OUT_W-1:0]     band_out_reg;

    logic [2:0]                           expo;
    logic [svftm_pkg::K_W-1:0]            coef_k;
    logic [svftm_pkg::QM_W-1:0]           coef_qm;
    logic [svftm_pkg::COEF_W-1:0]         coef_kq;
    logic [CW-1:0]                        band64;
    logic [CW-1:0]                        low64;
    logic signed [CW-1:0]                 low_sx;
    logic signed [CW-1:0]                 low_shift;
    logic signed [CW-1:0]                 x64;
    logic                                 prod_state;
    logic                                 out_load;

    svftm_pkg::mul_req_t req;
    svftm_pkg::mul_rsp_t rsp;

    // Coefficients from the cutoff and resonance registers
    always_comb
    begin
        expo      = cutoff_reg[11:9];
        coef_k    = svftm_pkg::K_OFFSET + svftm_pkg::K_W'(cutoff_reg[8:1]);
        coef_qm   = svftm_pkg::DAMP_TABLE[resonance_reg];
        coef_kq   = svftm_pkg::COEF_W'(coef_k) * svftm_pkg::COEF_W'(coef_qm);
        band64    = CW'(band_reg);
        low64     = CW'(low_reg);
        low_sx    = CW'(low_reg);
        low_shift = low_sx >>> frac_reg;
        x64       = CW'(x_reg);
    end

    // Product request for the current step
    always_comb
    begin
        prod_state = (state_reg == S_INPUT) || (state_reg == S_DAMP) ||
                     (state_reg == S_CHAIN) || (state_reg == S_LOW);
        req        = '0;
        req.start  = prod_state && !wait_reg;
        unique case (state_reg)
            S_INPUT:
            begin
                req.setup = in_setup_reg;
                req.coef  = svftm_pkg::COEF_W'(coef_k);
                req.data  = (x64 << frac_reg) - low64;
                req.col   = svftm_pkg::COL_INPUT_BASE + svftm_pkg::COL_W'(frac_reg);
            end
            S_DAMP:
            begin
                req.setup = damp_setup_reg;
                req.data  = band64;
                if (order_reg)
                begin
                    req.coef = svftm_pkg::COEF_W'(coef_k);
                    req.col  = svftm_pkg::COL_DAMP_FIRST - svftm_pkg::COL_W'(expo);
                end
                else
                begin
                    req.coef = coef_kq;
                    req.col  = svftm_pkg::COL_DAMP_SINGLE - svftm_pkg::COL_W'(expo);
                end
            end
            S_CHAIN:
            begin
                req.setup = damp_setup_reg;
                req.coef  = svftm_pkg::COEF_W'(coef_qm);
                req.data  = tmp_reg;
                req.col   = svftm_pkg::COL_DAMP_CHAIN;
            end
            S_LOW:
            begin
                req.setup = low_setup_reg;
                req.coef  = svftm_pkg::COEF_W'(coef_k);
                req.data  = band64;
                req.col   = svftm_pkg::COL_LOW_BASE - svftm_pkg::COL_W'({expo, 1'b0})
                            - svftm_pkg::COL_W'(frac_reg);
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    svftm_mul_unit #(
        .BOOTH_DIGITS (BOOTH_DIGITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_INPUT;
                end
            end
            S_INPUT:
            begin
                if (rsp.done)
                begin
                    state_next = S_DAMP;
                end
            end
            S_DAMP:
            begin
                if (rsp.done)
                begin
                    state_next = order_reg ? S_CHAIN : S_LOW;
                end
            end
            S_CHAIN:
            begin
                if (rsp.done)
                begin
                    state_next = S_LOW;
                end
            end
            S_LOW:
            begin
                if (rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and integrator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wait_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            cutoff_reg     <= '0;
            resonance_reg  <= '0;
            frac_reg       <= '0;
            order_reg      <= 1'b0;
            in_setup_reg   <= '0;
            damp_setup_reg <= '0;
            low_setup_reg  <= '0;
            band_reg       <= '0;
            low_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // hold the outstanding-product flag from request to response
            if (req.start)
            begin
                wait_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                wait_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // write a configuration register
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    svftm_pkg::CFG_CUTOFF:       cutoff_reg     <= cfg_data;
                    svftm_pkg::CFG_RESONANCE:    resonance_reg  <= cfg_data[4:0];
                    svftm_pkg::CFG_LOW_FRACTION: frac_reg       <= cfg_data[3:0];
                    svftm_pkg::CFG_DAMP_ORDER:   order_reg      <= cfg_data[0];
                    svftm_pkg::CFG_INPUT_SETUP:  in_setup_reg   <= cfg_data[7:0];
                    svftm_pkg::CFG_DAMP_SETUP:   damp_setup_reg <= cfg_data[7:0];
                    svftm_pkg::CFG_LOW_SETUP:    low_setup_reg  <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            // subtract damping term, wrap band to the state width
            if (rsp.done && (((state_reg == S_DAMP) && !order_reg) || (state_reg == S_CHAIN)))
            begin
                band_reg <= STATE_WIDTH'(part_reg - rsp.result);
            end

            // advance the low integrator
            if (rsp.done && (state_reg == S_LOW))
            begin
                low_reg <= STATE_WIDTH'(low64 + rsp.result);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= sample_eighths;
        end
        if (rsp.done && (state_reg == S_INPUT))
        begin
            part_reg <= band64 + rsp.result;
        end
        if (rsp.done && (state_reg == S_DAMP))
        begin
            tmp_reg <= rsp.result;
        end
        if (out_load)
        begin
            low_out_reg  <= low_shift[svftm_pkg::LOW_OUT_W-1:0];
            band_out_reg <= band64[svftm_pkg::BAND_OUT_W-1:0];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign low_out   = low_out_reg;
    assign band_out  = band_out_reg;

`ifndef NO_ASSERTIONS
    // product unit answers only while a request is outstanding
    a_done_when_waiting: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.done |-> wait_reg
    ) else $error("product response without outstanding request");

    // a new transaction starts with the product unit quiet
    a_accept_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!wait_reg && !rsp.done)
    ) else $error("transaction accepted while a product is in flight");

    // band integrator moves only at the end of the damping products
    a_band_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$stable(band_reg) |-> ($past(state_reg) == S_DAMP || $past(state_reg) == S_CHAIN)
    ) else $error("band integrator changed outside the damping step");
`endif

endmodule

### sv/svftm_mul_unit.sv
// Shared product unit: radix-4 Booth row accumulator, one digit per cycle,
// then a rounding step. Depends on svftm_pkg.
module svftm_mul_unit #(
    parameter int BOOTH_DIGITS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  svftm_pkg::mul_req_t req,
    output svftm_pkg::mul_rsp_t rsp
);

    localparam int CW    = svftm_pkg::CALC_W;
    localparam int REC_W = 2 * BOOTH_DIGITS;

    typedef enum logic [2:0] {
        U_IDLE  = 3'b001,
        U_STEP  = 3'b010,
        U_ROUND = 3'b100
    } ustate_t;

    ustate_t state_reg, state_next;
    logic    done_reg;

    logic [CW-1:0]                psh_reg;
    logic [CW-1:0]                mask_reg;
    logic [CW-1:0]                acc_reg;
    logic [CW-1:0]                result_reg;
    logic [REC_W-1:0]             rec_reg;
    logic                         prev_reg;
    logic                         exact_reg;
    logic [1:0]                   rnd_reg;
    logic [svftm_pkg::COL_W-1:0]  twoj_reg;
    logic [svftm_pkg::COL_W-1:0]  trunc_reg;
    logic [svftm_pkg::COL_W-1:0]  gs_reg;

    logic                         load_exact;
    logic                         load_rec_data;
    logic [svftm_pkg::COL_W-1:0]  load_trunc;

    logic                         b0;
    logic                         b1;
    logic                         dig_zero;
    logic                         dig_neg;
    logic                         dig_dbl;
    logic [CW-1:0]                mag;
    logic [CW-1:0]                row;
    logic [CW-1:0]                hot;
    logic [REC_W-1:0]             rec_shift;
    logic                         digits_done;

    logic [CW-1:0]                half;
    logic [CW-1:0]                low_mask;
    logic [CW-1:0]                rnd_add;
    logic                         zero_ext;
    logic [CW-1:0]                pre;

    logic signed [CW:0]           sh_in;
    logic [svftm_pkg::COL_W-1:0]  sh_amt;
    logic signed [CW:0]           sh_out;

    // Decode a new request: pick recoded operand and truncation column
    always_comb
    begin
        load_exact    = (req.setup.model == svftm_pkg::MODEL_EXACT);
        load_rec_data = (req.setup.model == svftm_pkg::MODEL_BOOTH_DATA);
        if (load_exact || (req.col <= svftm_pkg::COL_W'(req.setup.guard)))
        begin
            load_trunc = '0;
        end
        else
        begin
            load_trunc = req.col - svftm_pkg::COL_W'(req.setup.guard);
        end
    end

    // Booth digit from the two low recoded bits and the previous high bit
    always_comb
    begin
        b0        = rec_reg[0];
        b1        = rec_reg[1];
        dig_zero  = (b1 == b0) && (b0 == prev_reg);
        dig_neg   = b1 && !(b0 && prev_reg);
        dig_dbl   = (b1 != b0) && (b0 == prev_reg);
        mag       = dig_dbl ? {psh_reg[CW-2:0], 1'b0} : psh_reg;
        // negative row: inverted magnitude with the low row columns cleared
        row       = dig_neg ? (~mag & mask_reg) : mag;
        if (!dig_zero && dig_neg && (twoj_reg >= trunc_reg))
        begin
            hot = CW'(1) << (twoj_reg - trunc_reg);
        end
        else
        begin
            hot = '0;
        end
        rec_shift   = {{2{rec_reg[REC_W-1]}}, rec_reg[REC_W-1:2]};
        // all remaining digits are zero once the rest matches the last high bit
        digits_done = (rec_shift == {REC_W{b1}});
    end

    // Rounding addend for the final column
    always_comb
    begin
        if (gs_reg == '0)
        begin
            half = '0;
        end
        else
        begin
            half = CW'(1) << (gs_reg - svftm_pkg::COL_W'(1));
        end
        low_mask = (CW'(1) << gs_reg) - CW'(1);
        zero_ext = 1'b0;
        rnd_add  = '0;
        if (exact_reg)
        begin
            case (rnd_reg)
                svftm_pkg::RND_FLOOR:
                begin
                    rnd_add = '0;
                end
                svftm_pkg::RND_TRUNC:
                begin
                    // toward zero: ceiling for negative values
                    rnd_add = acc_reg[CW-1] ? low_mask : '0;
                end
                svftm_pkg::RND_HALF_AWAY:
                begin
                    // positive side keeps the carry out of the top bit
                    rnd_add  = acc_reg[CW-1] ? (half - CW'(1)) : half;
                    zero_ext = !acc_reg[CW-1];
                end
                default:
                begin
                    rnd_add = half;
                end
            endcase
        end
        else if (rnd_reg != svftm_pkg::RND_FLOOR)
        begin
            rnd_add = half;
        end
        pre = acc_reg + rnd_add;
    end

    // Shared arithmetic right shifter: row truncation or final rounding
    always_comb
    begin
        if (state_reg == U_STEP)
        begin
            sh_in  = {row[CW-1], row};
            sh_amt = trunc_reg;
        end
        else
        begin
            sh_in  = {(zero_ext ? 1'b0 : pre[CW-1]), pre};
            sh_amt = gs_reg;
        end
        sh_out = sh_in >>> sh_amt;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    state_next = U_STEP;
                end
            end
            U_STEP:
            begin
                if (digits_done)
                begin
                    state_next = U_ROUND;
                end
            end
            U_ROUND:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == U_ROUND);
        end
    end

    // Operand, accumulator and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && req.start)
        begin
            psh_reg   <= load_rec_data ? CW'(req.coef) : req.data;
            rec_reg   <= load_rec_data ? req.data[REC_W-1:0] : REC_W'(req.coef);
            mask_reg  <= '1;
            acc_reg   <= '0;
            prev_reg  <= 1'b0;
            twoj_reg  <= '0;
            exact_reg <= load_exact;
            rnd_reg   <= req.setup.rnd;
            trunc_reg <= load_trunc;
            gs_reg    <= req.col - load_trunc;
        end
        else if (state_reg == U_STEP)
        begin
            // accumulate one truncated row and advance to the next digit
            acc_reg  <= acc_reg + (dig_zero ? '0 : sh_out[CW-1:0]) + hot;
            psh_reg  <= {psh_reg[CW-3:0], 2'b00};
            mask_reg <= {mask_reg[CW-3:0], 2'b00};
            rec_reg  <= rec_shift;
            prev_reg <= b1;
            twoj_reg <= twoj_reg + svftm_pkg::COL_W'(2);
        end
        if (state_reg == U_ROUND)
        begin
            result_reg <= sh_out[CW-1:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule
